FILE: sv/ffha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator: the datapath
// command codes, the status bundle and the field layout of the streams.
// ----------------------------------------------------------------------------
package ffha_pkg;

  // field widths fixed by the stream layout
  localparam int REQ_W   = 13;
  localparam int UOFF_W  = 12;
  localparam int USED_W  = 13;
  localparam int CFG_W   = 13;
  localparam int TDATA_W = 32;

  // largest user offset the granted field can carry
  localparam int OFFSET_MAX = 4095;

  // register reset values
  localparam int HEAP_SIZE_RST = 4096;
  localparam int MIN_SPLIT_RST = 16;

  // configuration register indexes
  localparam logic REG_HEAP_SIZE = 1'b0;
  localparam logic REG_MIN_SPLIT = 1'b1;

  // datapath commands issued by the controller
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_START,
    CMD_A_READ,
    CMD_A_NEXT,
    CMD_A_SPLIT1,
    CMD_A_SPLIT2,
    CMD_A_UNLINK,
    CMD_A_TAKE,
    CMD_F_READ,
    CMD_F_STEP,
    CMD_F_READB,
    CMD_F_MARK,
    CMD_F_UNLINKN,
    CMD_F_READP,
    CMD_F_MERGEP,
    CMD_F_PUSH1,
    CMD_F_PUSH2,
    CMD_FAIL,
    CMD_EMIT
  } cmd_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic op_free;
    logic cur_null;
    logic guard_over;
    logic fits;
    logic do_split;
    logic f_bad;
    logic walk_done;
    logic cur_is_b;
    logic sz_zero;
    logic flag_set;
    logic nxt_merge;
    logic prev_valid;
    logic emit_ok;
  } stat_t;

endpackage

FILE: sv/ffha_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ctrl
// Controller of the allocator: sequences the free-list walk of an allocate
// and the physical chain walk and merges of a free.
// ----------------------------------------------------------------------------
module ffha_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  ffha_pkg::stat_t  stat,
  output ffha_pkg::cmd_t   cmd
);

  typedef enum logic [4:0] {
    IDLE, BRANCH, A_LOOP, A_CHK, A_SPLIT1, A_SPLIT2, A_UNLINK, A_TAKE,
    F_LOOP, F_WALK, F_RDB, F_B, F_N, F_RDP, F_P, F_PUSH1, F_PUSH2,
    FAILED, DONE
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == IDLE);

  // next state and command decode
  always_comb begin
    state_next = state;
    cmd        = ffha_pkg::CMD_NONE;
    case (state)
      IDLE: begin
        if (s_tvalid) begin
          cmd        = ffha_pkg::CMD_START;
          state_next = BRANCH;
        end
      end
      BRANCH: begin
        if (!stat.op_free) state_next = A_LOOP;
        else if (stat.f_bad) state_next = FAILED;
        else state_next = F_LOOP;
      end
      A_LOOP: begin
        if (stat.cur_null || stat.guard_over) begin
          state_next = FAILED;
        end else begin
          cmd        = ffha_pkg::CMD_A_READ;
          state_next = A_CHK;
        end
      end
      A_CHK: begin
        if (stat.fits) begin
          state_next = stat.do_split ? A_SPLIT1 : A_UNLINK;
        end else begin
          cmd        = ffha_pkg::CMD_A_NEXT;
          state_next = A_LOOP;
        end
      end
      A_SPLIT1: begin
        cmd        = ffha_pkg::CMD_A_SPLIT1;
        state_next = A_SPLIT2;
      end
      A_SPLIT2: begin
        cmd        = ffha_pkg::CMD_A_SPLIT2;
        state_next = A_TAKE;
      end
      A_UNLINK: begin
        cmd        = ffha_pkg::CMD_A_UNLINK;
        state_next = A_TAKE;
      end
      A_TAKE: begin
        cmd        = ffha_pkg::CMD_A_TAKE;
        state_next = DONE;
      end
      F_LOOP: begin
        if (stat.walk_done) begin
          state_next = stat.cur_is_b ? F_RDB : FAILED;
        end else begin
          cmd        = ffha_pkg::CMD_F_READ;
          state_next = F_WALK;
        end
      end
      F_WALK: begin
        if (stat.sz_zero) begin
          state_next = FAILED;
        end else begin
          cmd        = ffha_pkg::CMD_F_STEP;
          state_next = F_LOOP;
        end
      end
      F_RDB: begin
        cmd        = ffha_pkg::CMD_F_READB;
        state_next = F_B;
      end
      F_B: begin
        if (stat.flag_set) begin
          state_next = FAILED;
        end else begin
          cmd        = ffha_pkg::CMD_F_MARK;
          state_next = F_N;
        end
      end
      F_N: begin
        if (stat.nxt_merge) cmd = ffha_pkg::CMD_F_UNLINKN;
        state_next = F_RDP;
      end
      F_RDP: begin
        if (stat.prev_valid) begin
          cmd        = ffha_pkg::CMD_F_READP;
          state_next = F_P;
        end else begin
          state_next = F_PUSH1;
        end
      end
      F_P: begin
        if (stat.flag_set) begin
          cmd        = ffha_pkg::CMD_F_MERGEP;
          state_next = DONE;
        end else begin
          state_next = F_PUSH1;
        end
      end
      F_PUSH1: begin
        cmd        = ffha_pkg::CMD_F_PUSH1;
        state_next = F_PUSH2;
      end
      F_PUSH2: begin
        cmd        = ffha_pkg::CMD_F_PUSH2;
        state_next = DONE;
      end
      FAILED: begin
        cmd        = ffha_pkg::CMD_FAIL;
        state_next = DONE;
      end
      DONE: begin
        if (stat.emit_ok) begin
          cmd        = ffha_pkg::CMD_EMIT;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/ffha_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_dp
// Datapath of the allocator: block header memories, walk registers, usage
// counter, configuration registers and the result register.
// ----------------------------------------------------------------------------
module ffha_dp #(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [ffha_pkg::CFG_W-1:0]          cfg_data,
  input  logic [ffha_pkg::TDATA_W-1:0]        s_tdata,
  input  logic [0:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ffha_pkg::TDATA_W-1:0]        m_tdata,
  input  ffha_pkg::cmd_t                      cmd,
  output ffha_pkg::stat_t                     stat
);

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int LW = AW + 1;
  localparam int W  = ((LW > ffha_pkg::CFG_W) ? LW : ffha_pkg::CFG_W) + 2;
  localparam logic [LW-1:0] NIL    = LW'(HEAP_BYTES);
  localparam logic [W-1:0]  HEAP_W = W'(HEAP_BYTES);
  localparam logic [W-1:0]  HDR_W  = W'(HEADER_BYTES);
  localparam logic [W-1:0]  OMAX_W = W'(ffha_pkg::OFFSET_MAX);
  localparam logic [W-1:0]  HRST_W = W'(ffha_pkg::HEAP_SIZE_RST);

  // block header memories
  logic [LW-1:0] size_mem [HEAP_BYTES];
  logic          flag_mem [HEAP_BYTES];
  logic [LW-1:0] next_mem [HEAP_BYTES];
  logic [LW-1:0] prev_mem [HEAP_BYTES];

  logic [LW-1:0] size_rd, next_rd, prev_rd;
  logic          flag_rd;

  // walk and bookkeeping registers
  logic          op_free, split, nxt_in;
  logic [W-1:0]  uoff, need, cur, b, prevb, bsz, guard;
  logic [W-1:0]  heap_size, min_split, used;
  logic [LW-1:0] head;
  logic          res_ok;
  logic [ffha_pkg::UOFF_W-1:0] res_off;

  logic [W-1:0] size_x, p_x, n_x, head_x, spare, nb, nxt_calc, heap_new, cfg_x, clamp_in;
  logic         p_valid, n_valid, head_valid, init;
  logic [W-1:0] in_req, in_uoff;

  logic         ren;
  logic [W-1:0] raddr;
  logic         size_we, flag_we, next_we, prev_we;
  logic [W-1:0] size_wa, flag_wa, next_wa, prev_wa;
  logic [LW-1:0] size_wd, next_wd, prev_wd;
  logic          flag_wd;

  assign size_x     = W'(size_rd);
  assign p_x        = W'(prev_rd);
  assign n_x        = W'(next_rd);
  assign head_x     = W'(head);
  assign p_valid    = p_x < HEAP_W;
  assign n_valid    = n_x < HEAP_W;
  assign head_valid = head_x < HEAP_W;
  assign spare      = size_x - need;
  assign nb         = cur + need;
  assign nxt_calc   = b + size_x;
  assign in_req     = W'(s_tdata[ffha_pkg::REQ_W-1:0]);
  assign in_uoff    = W'(s_tdata[ffha_pkg::REQ_W +: ffha_pkg::UOFF_W]);

  // heap size clamp, applied at reset and on a register write
  assign cfg_x    = W'(cfg_data);
  assign clamp_in = rst ? HRST_W : cfg_x;
  always_comb begin
    heap_new = clamp_in;
    if (heap_new > HEAP_W) heap_new = HEAP_W;
    if (heap_new < HDR_W) heap_new = HDR_W;
  end
  assign init = rst || (cfg_we && (cfg_index == ffha_pkg::REG_HEAP_SIZE));

  // status towards the controller
  always_comb begin
    stat.op_free    = op_free;
    stat.cur_null   = cur >= HEAP_W;
    stat.guard_over = guard > HEAP_W;
    stat.fits       = (size_x >= need) && ((cur + HDR_W) <= OMAX_W);
    stat.do_split   = spare > (HDR_W + min_split);
    stat.f_bad      = (uoff == '0) || (uoff < HDR_W) || ((uoff - HDR_W) >= heap_size);
    stat.walk_done  = (cur >= heap_size) || (cur == b);
    stat.cur_is_b   = cur == b;
    stat.sz_zero    = size_rd == '0;
    stat.flag_set   = flag_rd;
    stat.nxt_merge  = nxt_in && flag_rd;
    stat.prev_valid = prevb < HEAP_W;
    stat.emit_ok    = !m_tvalid || m_tready;
  end

  // read port address
  always_comb begin
    ren   = 1'b0;
    raddr = cur;
    case (cmd)
      ffha_pkg::CMD_A_READ,
      ffha_pkg::CMD_F_READ: begin
        ren   = 1'b1;
        raddr = cur;
      end
      ffha_pkg::CMD_F_READB: begin
        ren   = 1'b1;
        raddr = b;
      end
      ffha_pkg::CMD_F_MARK: begin
        ren   = nxt_calc < heap_size;
        raddr = nxt_calc;
      end
      ffha_pkg::CMD_F_READP: begin
        ren   = 1'b1;
        raddr = prevb;
      end
      default: ren = 1'b0;
    endcase
  end

  // write ports, one per memory
  always_comb begin
    size_we = 1'b0; size_wa = cur; size_wd = size_rd;
    flag_we = 1'b0; flag_wa = cur; flag_wd = 1'b0;
    next_we = 1'b0; next_wa = cur; next_wd = NIL;
    prev_we = 1'b0; prev_wa = cur; prev_wd = NIL;
    if (init) begin
      size_we = 1'b1; size_wa = '0; size_wd = LW'(heap_new);
      flag_we = 1'b1; flag_wa = '0; flag_wd = 1'b1;
      next_we = 1'b1; next_wa = '0; next_wd = NIL;
      prev_we = 1'b1; prev_wa = '0; prev_wd = NIL;
    end else begin
      case (cmd)
        ffha_pkg::CMD_A_SPLIT1: begin
          size_we = 1'b1; size_wa = nb; size_wd = LW'(spare);
          flag_we = 1'b1; flag_wa = nb; flag_wd = 1'b1;
          next_we = 1'b1; next_wa = nb; next_wd = next_rd;
          prev_we = 1'b1; prev_wa = nb; prev_wd = prev_rd;
        end
        ffha_pkg::CMD_A_SPLIT2: begin
          next_we = p_valid; next_wa = p_x; next_wd = LW'(nb);
          prev_we = n_valid; prev_wa = n_x; prev_wd = LW'(nb);
        end
        ffha_pkg::CMD_A_UNLINK,
        ffha_pkg::CMD_F_UNLINKN: begin
          next_we = p_valid; next_wa = p_x; next_wd = next_rd;
          prev_we = n_valid; prev_wa = n_x; prev_wd = prev_rd;
          if (cmd == ffha_pkg::CMD_F_UNLINKN) begin
            size_we = 1'b1; size_wa = b; size_wd = LW'(bsz + size_x);
          end
        end
        ffha_pkg::CMD_A_TAKE: begin
          size_we = split; size_wa = cur; size_wd = LW'(need);
          flag_we = 1'b1;  flag_wa = cur; flag_wd = 1'b0;
          next_we = 1'b1;  next_wa = cur; next_wd = NIL;
          prev_we = 1'b1;  prev_wa = cur; prev_wd = NIL;
        end
        ffha_pkg::CMD_F_MARK: begin
          flag_we = 1'b1; flag_wa = b; flag_wd = 1'b1;
        end
        ffha_pkg::CMD_F_MERGEP: begin
          size_we = 1'b1; size_wa = prevb; size_wd = LW'(size_x + bsz);
        end
        ffha_pkg::CMD_F_PUSH1: begin
          next_we = 1'b1; next_wa = b; next_wd = head;
          prev_we = 1'b1; prev_wa = b; prev_wd = NIL;
        end
        ffha_pkg::CMD_F_PUSH2: begin
          prev_we = head_valid; prev_wa = head_x; prev_wd = LW'(b);
        end
        default: size_we = 1'b0;
      endcase
    end
  end

  // memories with registered read data
  always_ff @(posedge clk) begin
    if (size_we) size_mem[size_wa[AW-1:0]] <= size_wd;
    if (flag_we) flag_mem[flag_wa[AW-1:0]] <= flag_wd;
    if (next_we) next_mem[next_wa[AW-1:0]] <= next_wd;
    if (prev_we) prev_mem[prev_wa[AW-1:0]] <= prev_wd;
    if (ren) begin
      size_rd <= size_mem[raddr[AW-1:0]];
      flag_rd <= flag_mem[raddr[AW-1:0]];
      next_rd <= next_mem[raddr[AW-1:0]];
      prev_rd <= prev_mem[raddr[AW-1:0]];
    end
  end

  // control and bookkeeping registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_size <= heap_new;
      min_split <= W'(ffha_pkg::MIN_SPLIT_RST);
      head      <= '0;
      used      <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == ffha_pkg::REG_HEAP_SIZE)) begin
        heap_size <= heap_new;
        head      <= '0;
        used      <= '0;
      end
      if (cfg_we && (cfg_index == ffha_pkg::REG_MIN_SPLIT)) min_split <= cfg_x;
      // result valid: set on emit, cleared when taken
      if (cmd == ffha_pkg::CMD_EMIT) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (cmd)
        ffha_pkg::CMD_START: begin
          op_free <= s_tuser[0];
          uoff    <= in_uoff;
          need    <= in_req + HDR_W;
          cur     <= s_tuser[0] ? '0 : head_x;
          b       <= in_uoff - HDR_W;
          prevb   <= W'(NIL);
          guard   <= '0;
          split   <= 1'b0;
        end
        ffha_pkg::CMD_A_NEXT: begin
          cur   <= n_x;
          guard <= guard + 1'b1;
        end
        ffha_pkg::CMD_A_SPLIT1: split <= 1'b1;
        ffha_pkg::CMD_A_SPLIT2: begin
          if (!p_valid) head <= LW'(nb);
        end
        ffha_pkg::CMD_A_UNLINK,
        ffha_pkg::CMD_F_UNLINKN: begin
          if (!p_valid) head <= next_rd;
          if (cmd == ffha_pkg::CMD_F_UNLINKN) bsz <= bsz + size_x;
        end
        ffha_pkg::CMD_A_TAKE: begin
          used    <= used + (split ? need : size_x);
          res_ok  <= 1'b1;
          res_off <= ffha_pkg::UOFF_W'(cur + HDR_W);
        end
        ffha_pkg::CMD_F_STEP: begin
          prevb <= cur;
          cur   <= cur + size_x;
        end
        ffha_pkg::CMD_F_MARK: begin
          used   <= used - size_x;
          bsz    <= size_x;
          nxt_in <= nxt_calc < heap_size;
        end
        ffha_pkg::CMD_F_MERGEP: begin
          res_ok  <= 1'b1;
          res_off <= '0;
        end
        ffha_pkg::CMD_F_PUSH2: begin
          head    <= LW'(b);
          res_ok  <= 1'b1;
          res_off <= '0;
        end
        ffha_pkg::CMD_FAIL: begin
          res_ok  <= 1'b0;
          res_off <= '0;
        end
        ffha_pkg::CMD_EMIT: begin
          m_tdata  <= {(ffha_pkg::TDATA_W - 1 - ffha_pkg::UOFF_W - ffha_pkg::USED_W)'(0),
                       ffha_pkg::USED_W'(used), res_off, res_ok};
        end
        default: op_free <= op_free;
      endcase
    end
  end

endmodule

FILE: sv/first_fit_heap_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit heap allocator with block splitting and coalescing on free.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream: s_tuser selects allocate (0) or free (1),
// s_tdata carries the request size and the user offset to free. Each request
// gives exactly one result on the m_ stream: ok flag, granted user offset and
// the allocated byte total after the request.
// An allocate walks the free list block by block to the first fit, then
// unlinks the whole block or splits it; a free walks the physical chain from
// offset 0 to the freed block, marks it free, merges a free next block into
// it, then merges it into a free previous block or pushes it onto the list.
// Both walks are set by the single read port of the header memories, so the
// time taken follows fragmentation.
// One request is in work at a time; s_tready is high only while idle. The
// result sits in an output register, so a new request is taken while the
// previous result still waits; a stalled receiver holds the block in its
// final step until the output register frees.
// Reset (synchronous) sets heap_size 4096 (clamped to HEAP_BYTES), min_split
// 16 and one free block over the arena; a heap_size write redoes the arena.
// Configuration is to be written only while idle; the block does not check.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top #(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [ffha_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // request_bytes [12:0], user_offset [24:13], zero [31:25]
  input  logic [ffha_pkg::TDATA_W-1:0] s_tdata,
  // op [0]
  input  logic [0:0]                   s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // ok [0], granted_offset [12:1], used_total [25:13], zero [31:26]
  output logic [ffha_pkg::TDATA_W-1:0] m_tdata
);

  ffha_pkg::cmd_t  cmd;
  ffha_pkg::stat_t stat;

  // controller
  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  ffha_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

FILE: sv/ffha_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffha_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [ffha_pkg::TDATA_W-1:0] m_tdata
);

  // one request in work at a time
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while a request was in work");

  // with no result waiting, none is shown in the cycle right after a request is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("result appeared without any work cycle");

  // failed results grant no offset
  a_fail_no_offset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[12:1] == '0)
    else $error("offset granted on a failed request");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: verif/first_fit_heap_allocator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top_tb
// Self-checking bench for the first-fit heap allocator. A behavioural copy of
// the arena (block sizes, free flags, free-list links) predicts every result;
// requests come from a queue through a clocked driver, results are checked
// in order by a clocked monitor, across several configurations and idling
// phases.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top_tb;

  localparam int HEAP_B = 4096;
  localparam int HDR_B  = 32;
  localparam int NIL    = HEAP_B;
  localparam int WDOG   = 200000;
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic        op;
    logic [12:0] req;
    logic [11:0] uoff;
  } alloc_req_t;

  typedef struct packed {
    logic        ok;
    logic [11:0] granted;
    logic [12:0] used;
  } alloc_res_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic                           cfg_index;
  logic [ffha_pkg::CFG_W-1:0]     cfg_data;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [ffha_pkg::TDATA_W-1:0]   s_tdata;
  logic [0:0]                     s_tuser;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [ffha_pkg::TDATA_W-1:0]   m_tdata;

  first_fit_heap_allocator_top #(.HEAP_BYTES(HEAP_B), .HEADER_BYTES(HDR_B)) uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // arena shadow
  int unsigned blk_size [HEAP_B];
  bit          blk_free [HEAP_B];
  int unsigned nxt_link [HEAP_B];
  int unsigned prv_link [HEAP_B];
  int unsigned list_head, used_sum, arena_bytes, split_min;
  int unsigned live_q[$];   // user offsets granted since the arena was last set up

  alloc_req_t pending_q[$];
  alloc_res_t expected_q[$];
  int   fail_cnt;
  int   idle_cnt;
  int   send_idle_pct, recv_idle_pct;

  function automatic void arena_reinit();
    foreach (blk_size[i]) begin
      blk_size[i] = 0; blk_free[i] = 0; nxt_link[i] = 0; prv_link[i] = 0;
    end
    blk_size[0] = arena_bytes;
    blk_free[0] = 1;
    nxt_link[0] = NIL;
    prv_link[0] = NIL;
    list_head = 0;
    used_sum = 0;
    live_q.delete();
  endfunction

  function automatic void set_arena(int unsigned v);
    v = v & 13'h1fff;
    if (v > HEAP_B) v = HEAP_B;
    if (v < HDR_B) v = HDR_B;
    arena_bytes = v;
    arena_reinit();
  endfunction

  function automatic void drop_from_list(int unsigned b);
    int unsigned p, n;
    p = prv_link[b];
    n = nxt_link[b];
    if (p < HEAP_B) nxt_link[p] = n;
    else list_head = n;
    if (n < HEAP_B) prv_link[n] = p;
  endfunction

  function automatic bit grant_block(int unsigned req, output int unsigned granted);
    int unsigned need, cur, guard, spare, nb, p, n;
    need = req + HDR_B;
    cur = list_head;
    guard = 0;
    granted = 0;
    while (cur < HEAP_B && guard <= HEAP_B) begin
      if (blk_size[cur] >= need && cur + HDR_B <= ffha_pkg::OFFSET_MAX) break;
      cur = nxt_link[cur];
      guard++;
    end
    if (cur >= HEAP_B || guard > HEAP_B) return 0;
    spare = blk_size[cur] - need;
    if (spare > HDR_B + split_min) begin
      nb = cur + need;
      p = prv_link[cur];
      n = nxt_link[cur];
      blk_size[nb] = spare;
      blk_free[nb] = 1;
      nxt_link[nb] = n;
      prv_link[nb] = p;
      if (p < HEAP_B) nxt_link[p] = nb;
      else list_head = nb;
      if (n < HEAP_B) prv_link[n] = nb;
      blk_size[cur] = need;
    end else begin
      drop_from_list(cur);
    end
    blk_free[cur] = 0;
    nxt_link[cur] = NIL;
    prv_link[cur] = NIL;
    used_sum += blk_size[cur];
    granted = cur + HDR_B;
    return 1;
  endfunction

  function automatic bit release_block(int unsigned uoff);
    int unsigned b, cur, prev, sz, nx;
    if (uoff < HDR_B) return 0;
    b = uoff - HDR_B;
    if (b >= arena_bytes) return 0;
    cur = 0;
    prev = NIL;
    while (cur < arena_bytes && cur != b) begin
      sz = blk_size[cur];
      if (sz == 0) return 0;
      prev = cur;
      cur += sz;
    end
    if (cur != b || blk_free[b]) return 0;
    used_sum -= blk_size[b];
    blk_free[b] = 1;
    nx = b + blk_size[b];
    if (nx < arena_bytes && blk_free[nx]) begin
      drop_from_list(nx);
      blk_size[b] += blk_size[nx];
    end
    if (prev < HEAP_B && blk_free[prev]) begin
      blk_size[prev] += blk_size[b];
    end else begin
      nxt_link[b] = list_head;
      prv_link[b] = NIL;
      if (list_head < HEAP_B) prv_link[list_head] = b;
      list_head = b;
    end
    return 1;
  endfunction

  // predicted result of one accepted request
  function automatic alloc_res_t predict_result(alloc_req_t r);
    alloc_res_t res;
    int unsigned g;
    bit ok;
    g = 0;
    if (r.op == OP_ALLOC) ok = grant_block(r.req, g);
    else ok = release_block(r.uoff);
    if (ok && r.op == OP_ALLOC) live_q.push_back(g);
    res.ok = ok;
    res.granted = g[11:0];
    res.used = used_sum[12:0];
    return res;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        alloc_req_t r;
        r = pending_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, r.uoff, r.req};
        s_tuser <= r.op;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // prediction at acceptance, result check, stall and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        alloc_req_t r;
        r.op = s_tuser[0];
        r.req = s_tdata[12:0];
        r.uoff = s_tdata[24:13];
        expected_q.push_back(predict_result(r));
      end
      if (m_tvalid && m_tready) begin
        alloc_res_t got, exp_r;
        got.ok = m_tdata[0];
        got.granted = m_tdata[12:1];
        got.used = m_tdata[25:13];
        if (expected_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("unexpected result %h", m_tdata);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch: exp ok=%0d off=%0d used=%0d got ok=%0d off=%0d used=%0d",
                       exp_r.ok, exp_r.granted, exp_r.used, got.ok, got.granted, got.used);
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (idle_cnt >= WDOG) begin
      $display("first_fit_heap_allocator_top_tb: FAIL");
      $finish;
    end
  end

  task automatic push_req(logic op, int unsigned req, int unsigned uoff);
    alloc_req_t r;
    r.op = op;
    r.req = req[12:0];
    r.uoff = uoff[11:0];
    pending_q.push_back(r);
  endtask

  // wait until all requests are answered and the block is quiet
  task automatic drain();
    while (pending_q.size() > 0 || s_tvalid || expected_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[12:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ffha_pkg::REG_HEAP_SIZE) set_arena(v);
    else split_min = v & 13'h1fff;
  endtask

  // mostly well-formed alloc/free traffic with some noise
  task automatic random_phase(int n);
    int unsigned k, big;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      big = $urandom_range(19) == 0;
      if (k < 50) begin
        push_req(OP_ALLOC, big ? $urandom_range(8191) : $urandom_range(300), $urandom);
      end else if (k < 90) begin
        // free a random live block, predicted in order on acceptance
        int unsigned off;
        off = (live_q.size() > 0) ? live_q[$urandom_range(live_q.size() - 1)]
                                  : $urandom_range(4095);
        push_req(OP_FREE, $urandom, off);
        // hold back until the driver takes it from the queue so live_q stays in step
        while (pending_q.size() > 0) @(posedge clk);
      end else begin
        push_req(OP_FREE, $urandom, $urandom_range(4095));
      end
      if (pending_q.size() > 4) while (pending_q.size() > 0) @(posedge clk);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = ffha_pkg::REG_HEAP_SIZE;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    fail_cnt = 0;
    idle_cnt = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    split_min = 16;
    set_arena(4096);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, null and invalid frees, double free, full arena
    push_req(OP_FREE, 0, 0);
    push_req(OP_ALLOC, 0, 4095);
    push_req(OP_ALLOC, 8191, 0);
    push_req(OP_ALLOC, 4064, 0);
    push_req(OP_FREE, 0, 32);
    push_req(OP_FREE, 0, 32);
    push_req(OP_FREE, 0, 31);
    push_req(OP_FREE, 0, 4095);
    push_req(OP_ALLOC, 100, 0);
    push_req(OP_ALLOC, 100, 0);
    push_req(OP_ALLOC, 100, 0);
    push_req(OP_FREE, 0, 164);
    push_req(OP_FREE, 0, 100);
    push_req(OP_FREE, 0, 32);
    push_req(OP_FREE, 0, 296);
    push_req(OP_ALLOC, 4000, 0);
    push_req(OP_ALLOC, 20, 0);
    push_req(OP_FREE, 8191, 32);
    push_req(OP_FREE, 0, 32);
    drain();

    // configuration phases with idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 57; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 57; end
        default: begin send_idle_pct = 26; recv_idle_pct = 26; end
      endcase
      case (ph)
        0: begin
          write_reg(ffha_pkg::REG_MIN_SPLIT, 0);
          write_reg(ffha_pkg::REG_HEAP_SIZE, 4096);
        end
        1: begin
          write_reg(ffha_pkg::REG_MIN_SPLIT, 4096);
          write_reg(ffha_pkg::REG_HEAP_SIZE, 64);
        end
        2: begin
          write_reg(ffha_pkg::REG_MIN_SPLIT, 16);
          write_reg(ffha_pkg::REG_HEAP_SIZE, 8191);
        end
        3: begin
          write_reg(ffha_pkg::REG_MIN_SPLIT, 8191);
          write_reg(ffha_pkg::REG_HEAP_SIZE, 5);
        end
        4: begin
          write_reg(ffha_pkg::REG_MIN_SPLIT, 64);
          write_reg(ffha_pkg::REG_HEAP_SIZE, 1000);
        end
        default: begin
          write_reg(ffha_pkg::REG_MIN_SPLIT, $urandom_range(128));
          write_reg(ffha_pkg::REG_HEAP_SIZE, $urandom_range(64, 4096));
        end
      endcase
      random_phase(225);
      drain();
    end

    if (fail_cnt == 0) $display("first_fit_heap_allocator_top_tb: PASS");
    else $display("first_fit_heap_allocator_top_tb: FAIL");
    $finish;
  end

endmodule
